// ----- rtl/spca_pkg.sv -----
// Shared types and constants for the SGM path cost aggregation block.
// Used by spca_cost_unit and sgm_path_cost_aggregation.
package spca_pkg;

	localparam int MATCH_W = 8;
	localparam int DISP_W  = 7;
	localparam int OUT_W   = 16;
	localparam int P1_W    = 8;
	localparam int P2_W    = 10;
	localparam int CNT_W   = 8;
	localparam int CFG_IDX_W = 2;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_PENALTY_SMALL   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PENALTY_LARGE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DISPARITY_COUNT = 2'd2;

	localparam logic [P1_W-1:0]  P1_RESET    = 8'd10;
	localparam logic [P2_W-1:0]  P2_RESET    = 10'd120;
	localparam logic [CNT_W-1:0] COUNT_RESET = 8'd64;
	localparam int               COUNT_HW_MAX = 128;

	typedef logic [MATCH_W-1:0] match_t;
	typedef logic [DISP_W-1:0]  disp_t;
	typedef logic [P1_W-1:0]    p1_t;
	typedef logic [P2_W-1:0]    p2_t;

	// neighbor selection for one element
	typedef struct packed {
		logic pass;     // first pixel of path: cost goes straight through
		logic use_left;
		logic use_right;
	} nbr_ctrl_t;

endpackage

// ----- rtl/spca_ram.sv -----
// One-write one-read RAM with registered, write-first read data.
// Standalone; holds one replica of the two path-cost banks.
module spca_ram #(
	parameter int ADDR_W = 8,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] wa,
	input  logic [DATA_W-1:0] wd,
	input  logic              re,
	input  logic [ADDR_W-1:0] ra,
	output logic [DATA_W-1:0] rd
);

	logic [DATA_W-1:0] mem [2**ADDR_W];
	logic [DATA_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	// a read colliding with the write of the same edge returns the new word
	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= (we && (wa == ra)) ? wd : mem[ra];
		end
	end

	assign rd = rd_q;

endmodule

// ----- rtl/spca_cost_unit.sv -----
// Path cost for one disparity: C + min(Lp[d], Lp[d+-1]+P1, minLp+P2) - minLp,
// saturated at the cost ceiling. Depends on spca_pkg.
module spca_cost_unit #(
	parameter int COST_BITS = 16
) (
	input  spca_pkg::nbr_ctrl_t          ctrl,
	input  spca_pkg::match_t             cost,
	input  logic [COST_BITS-1:0]         prev_c,
	input  logic [COST_BITS-1:0]         prev_l,
	input  logic [COST_BITS-1:0]         prev_r,
	input  logic [COST_BITS-1:0]         prev_min,
	input  spca_pkg::p1_t                p1,
	input  spca_pkg::p2_t                p2,
	output logic [COST_BITS-1:0]         value
);
	import spca_pkg::*;

	localparam int VW = COST_BITS + 2;
	localparam logic [VW-1:0] CEIL = VW'((64'd1 << COST_BITS) - 64'd1);

	logic [VW-1:0] cand_l, cand_r, cand_g, best0, best1, best, diff, sum;

	always_comb begin
		cand_l = VW'(prev_l) + VW'(p1);
		cand_r = VW'(prev_r) + VW'(p1);
		cand_g = VW'(prev_min) + VW'(p2);
		best0  = (ctrl.use_left && (cand_l < VW'(prev_c))) ? cand_l : VW'(prev_c);
		best1  = (ctrl.use_right && (cand_r < best0)) ? cand_r : best0;
		best   = (cand_g < best1) ? cand_g : best1;
		diff   = (best > VW'(prev_min)) ? (best - VW'(prev_min)) : '0;
		sum    = ctrl.pass ? VW'(cost) : (VW'(cost) + diff);
		value  = (sum > CEIL) ? CEIL[COST_BITS-1:0] : sum[COST_BITS-1:0];
	end

endmodule

// ----- rtl/sgm_path_cost_aggregation.sv -----
// Top level of the SGM path cost aggregation block: input register, three
// replicated path-cost RAMs, cost unit and output register. Depends on spca_pkg.
//
// Usage:
// Cost elements arrive on the cost channel (cost_valid / cost_stall) with
// match_cost, disparity_index and path_start; each pixel's disparities come
// in ascending order from 0, path_start marks the first pixel of a path.
// Each element gives one result on the result channel (result_valid /
// result_stall): path_cost, out_disparity, and pixel_last on the pixel's last
// disparity. An element is held in the input register and then in the output
// register, which drives result_valid; one element is taken every cycle while
// cost_stall is low. The previous pixel's costs sit in two RAM banks that swap
// at each pixel end; three RAM replicas give Lp[d-1], Lp[d], Lp[d+1] together,
// and a write-first read covers the element just written.
// Registers (penalty_small, penalty_large, disparity_count) are written over
// cfg_valid / cfg_ready / cfg_index / cfg_data; cfg_ready is always high, and
// writes are meant for an idle block. Reset loads the register defaults and
// makes the first pixel pass its costs through; the RAMs are not cleared.
// When result_stall is high the result holds, one more element is taken into
// the input register, and cost_stall then rises until the result moves.
module sgm_path_cost_aggregation #(
	parameter int MAX_DISPARITIES = 128,
	parameter int COST_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cost_valid,
	output logic                                  cost_stall,
	input  spca_pkg::match_t                      match_cost,
	input  spca_pkg::disp_t                       disparity_index,
	input  logic                                  path_start,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic [spca_pkg::OUT_W-1:0]            path_cost,
	output spca_pkg::disp_t                       out_disparity,
	output logic                                  pixel_last,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [spca_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [15:0]                           cfg_data
);
	import spca_pkg::*;

	localparam int AW = (MAX_DISPARITIES > 1) ? $clog2(MAX_DISPARITIES) : 1;
	localparam int RAW = AW + 1;
	localparam int N_LIM = (MAX_DISPARITIES < COUNT_HW_MAX) ? MAX_DISPARITIES : COUNT_HW_MAX;
	localparam int OW = ((COST_BITS > OUT_W) ? COST_BITS : OUT_W) + 1;
	localparam logic [COST_BITS-1:0] CEIL = COST_BITS'((64'd1 << COST_BITS) - 64'd1);
	localparam logic [OW-1:0] OUT_MAX = OW'((64'd1 << OUT_W) - 64'd1);

	// configuration
	p1_t              p1_q;
	p2_t              p2_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] n_eff;

	// state
	logic                 bank_q;
	logic                 first_q;
	logic [COST_BITS-1:0] pmin_q;
	logic [COST_BITS-1:0] rmin_q;

	// input register
	logic   vld_s1;
	match_t cost_s1;
	disp_t  disp_s1;
	logic   start_s1;

	// output register
	logic               vld_s2;
	logic [OUT_W-1:0]   cost_s2;
	disp_t              disp_s2;
	logic               last_s2;

	logic                 accept, adv_s1, upd, in_range, is_last, fpa;
	logic                 rd_bank;
	disp_t                d_left, d_right;
	logic [RAW-1:0]       wa, ra_c, ra_l, ra_r;
	logic [COST_BITS-1:0] rd_c, rd_l, rd_r, value, rmin_nx;
	logic [OW-1:0]        value_w;
	nbr_ctrl_t            ctrl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1_q    <= P1_RESET;
			p2_q    <= P2_RESET;
			count_q <= COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PENALTY_SMALL:   p1_q    <= cfg_data[P1_W-1:0];
				REG_PENALTY_LARGE:   p2_q    <= cfg_data[P2_W-1:0];
				REG_DISPARITY_COUNT: count_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (count_q > CNT_W'(N_LIM)) begin
			n_eff = CNT_W'(N_LIM);
		end else begin
			n_eff = count_q;
		end
	end

	// handshake
	assign adv_s1     = vld_s1 && (!vld_s2 || !result_stall);
	assign cost_stall = vld_s1 && !adv_s1;
	assign accept     = cost_valid && !cost_stall;

	// element in the input register
	assign in_range = {1'b0, disp_s1} < n_eff;
	assign is_last  = {1'b0, disp_s1} == (n_eff - CNT_W'(1));
	assign fpa      = first_q || start_s1;
	assign upd      = adv_s1 && in_range;

	always_comb begin
		ctrl.pass      = fpa;
		ctrl.use_left  = disp_s1 != '0;
		ctrl.use_right = ({1'b0, disp_s1} + CNT_W'(1)) < n_eff;
	end

	// write current bank; read the bank that is previous after this edge
	assign wa      = {bank_q, AW'(disp_s1)};
	assign rd_bank = ~(bank_q ^ (upd && is_last));
	assign d_left  = disparity_index - DISP_W'(1);
	assign d_right = disparity_index + DISP_W'(1);
	assign ra_c    = {rd_bank, AW'(disparity_index)};
	assign ra_l    = {rd_bank, AW'(d_left)};
	assign ra_r    = {rd_bank, AW'(d_right)};

	spca_ram #(.ADDR_W(RAW), .DATA_W(COST_BITS)) u_ram_c (
		.clk(clk), .we(upd), .wa(wa), .wd(value), .re(accept), .ra(ra_c), .rd(rd_c)
	);
	spca_ram #(.ADDR_W(RAW), .DATA_W(COST_BITS)) u_ram_l (
		.clk(clk), .we(upd), .wa(wa), .wd(value), .re(accept), .ra(ra_l), .rd(rd_l)
	);
	spca_ram #(.ADDR_W(RAW), .DATA_W(COST_BITS)) u_ram_r (
		.clk(clk), .we(upd), .wa(wa), .wd(value), .re(accept), .ra(ra_r), .rd(rd_r)
	);

	spca_cost_unit #(.COST_BITS(COST_BITS)) u_cost (
		.ctrl(ctrl),
		.cost(cost_s1),
		.prev_c(rd_c),
		.prev_l(rd_l),
		.prev_r(rd_r),
		.prev_min(pmin_q),
		.p1(p1_q),
		.p2(p2_q),
		.value(value)
	);

	assign rmin_nx = (value < rmin_q) ? value : rmin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q  <= 1'b0;
			first_q <= 1'b1;
			pmin_q  <= '0;
			rmin_q  <= CEIL;
		end else if (upd) begin
			if (is_last) begin
				bank_q  <= ~bank_q;
				first_q <= 1'b0;
				pmin_q  <= rmin_nx;
				rmin_q  <= CEIL;
			end else begin
				first_q <= fpa;
				rmin_q  <= rmin_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (adv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cost_s1  <= match_cost;
			disp_s1  <= disparity_index;
			start_s1 <= path_start;
		end
	end

	// out-of-range elements pass the raw cost
	assign value_w = in_range ? OW'(value) : OW'(cost_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s1) begin
			vld_s2 <= 1'b1;
		end else if (!result_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			cost_s2 <= (value_w > OUT_MAX) ? OUT_MAX[OUT_W-1:0] : value_w[OUT_W-1:0];
			disp_s2 <= disp_s1;
			last_s2 <= in_range && is_last;
		end
	end

	assign result_valid  = vld_s2;
	assign path_cost     = cost_s2;
	assign out_disparity = disp_s2;
	assign pixel_last    = last_s2;

endmodule
